@@ rtl/core/ghd_pkg.sv @@
// Shared types, constants and the arctangent table for the heading core.
`timescale 1ns / 1ps

package ghd_pkg;

    localparam int POS_W        = 40;   // position fields, 1/1024 m
    localparam int DIFF_W       = 32;   // saturated displacement
    localparam int THR_W        = 16;
    localparam int ANG_W        = 16;   // heading and quaternion outputs
    localparam int CORDIC_W     = 36;   // x/y datapath with gain headroom
    localparam int Z_W          = 35;   // angle accumulator, pi/2^31 units
    localparam int ATAN_W       = 30;
    localparam int ATAN_ENTRIES = 24;
    localparam int ITER_W       = $clog2(ATAN_ENTRIES);
    localparam int CFG_IDX_W    = 2;

    localparam logic [THR_W-1:0]        THRESHOLD_RST = 16'd307;
    localparam logic signed [POS_W-1:0] OFFSET_X_RST  = 40'sd369614582;
    localparam logic signed [POS_W-1:0] OFFSET_Y_RST  = 40'sd4163399014;
    // 1.0 / CORDIC gain at scale 2^30
    localparam logic signed [CORDIC_W-1:0] GAIN_INV   = 36'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVE_THRESHOLD = 2'd0,
        CFG_MAP_OFFSET_X   = 2'd1,
        CFG_MAP_OFFSET_Y   = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CMP,
        ST_VEC_INIT,
        ST_VEC,
        ST_H_ROUND,
        ST_ROT,
        ST_Q_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load_in;
        logic              diff;
        logic              sq_x;
        logic              sq_y;
        logic              vec_init;
        logic              step;
        logic              rot_mode;
        logic              h_round;
        logic              q_round;
        logic              out_load;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic moved;
    } dp_status_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [ATAN_W-1:0] a;
        unique case (i)
            5'd0:    a = 30'd536870912;
            5'd1:    a = 30'd316933406;
            5'd2:    a = 30'd167458907;
            5'd3:    a = 30'd85004756;
            5'd4:    a = 30'd42667331;
            5'd5:    a = 30'd21354465;
            5'd6:    a = 30'd10680862;
            5'd7:    a = 30'd5340245;
            5'd8:    a = 30'd2670163;
            5'd9:    a = 30'd1335087;
            5'd10:   a = 30'd667544;
            5'd11:   a = 30'd333772;
            5'd12:   a = 30'd166886;
            5'd13:   a = 30'd83443;
            5'd14:   a = 30'd41722;
            5'd15:   a = 30'd20861;
            5'd16:   a = 30'd10430;
            5'd17:   a = 30'd5215;
            5'd18:   a = 30'd2608;
            5'd19:   a = 30'd1304;
            5'd20:   a = 30'd652;
            5'd21:   a = 30'd326;
            5'd22:   a = 30'd163;
            5'd23:   a = 30'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/ghd_ctrl.sv @@
// Sequencer for the heading core: handshakes, phase control, CORDIC iteration count.
`timescale 1ns / 1ps

module ghd_ctrl #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output ghd_pkg::dp_cmd_t    cmd,
    input  ghd_pkg::dp_status_t status
);
    import ghd_pkg::*;

    localparam int N_ITER = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                               : ATAN_ENTRIES;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(N_ITER - 1);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.iter   = iter_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQ_X;
            end
            ST_SQ_X: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                cmd.sq_y   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = status.moved ? ST_VEC_INIT : ST_DONE;
            end
            ST_VEC_INIT: begin
                cmd.vec_init = 1'b1;
                iter_next    = '0;
                state_next   = ST_VEC;
            end
            ST_VEC: begin
                cmd.step = 1'b1;
                if (iter_reg == LAST_ITER) begin
                    state_next = ST_H_ROUND;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_H_ROUND: begin
                cmd.h_round = 1'b1;
                iter_next   = '0;
                state_next  = ST_ROT;
            end
            ST_ROT: begin
                cmd.step     = 1'b1;
                cmd.rot_mode = 1'b1;
                if (iter_reg == LAST_ITER) begin
                    state_next = ST_Q_ROUND;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_Q_ROUND: begin
                cmd.q_round = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_iter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (iter_reg <= LAST_ITER))
        else $error("CORDIC iteration index out of range");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !s_ready)
        else $error("request accepted while CORDIC busy");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ rtl/core/ghd_datapath.sv @@
// Datapath: config registers, anchor and held pose, squares, shared CORDIC, result registers.
`timescale 1ns / 1ps

module ghd_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ghd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ghd_pkg::POS_W-1:0]            cfg_wr_data,
    input  logic signed [ghd_pkg::POS_W-1:0]     s_fix_x,
    input  logic signed [ghd_pkg::POS_W-1:0]     s_fix_y,
    input  ghd_pkg::dp_cmd_t                     cmd,
    output ghd_pkg::dp_status_t                  status,
    output logic                                 m_pose_valid,
    output logic signed [ghd_pkg::ANG_W-1:0]     m_heading,
    output logic signed [ghd_pkg::ANG_W-1:0]     m_quat_z,
    output logic signed [ghd_pkg::ANG_W-1:0]     m_quat_w,
    output logic signed [ghd_pkg::POS_W-1:0]     m_map_x,
    output logic signed [ghd_pkg::POS_W-1:0]     m_map_y
);
    import ghd_pkg::*;

    // 41-bit difference saturated to signed 32
    function automatic logic signed [DIFF_W-1:0] sat_diff(input logic signed [POS_W:0] v);
        logic signed [DIFF_W-1:0] r;
        if (&v[POS_W:DIFF_W-1] || ~|v[POS_W:DIFF_W-1]) begin
            r = v[DIFF_W-1:0];
        end else begin
            r = v[POS_W] ? {1'b1, {(DIFF_W-1){1'b0}}} : {1'b0, {(DIFF_W-1){1'b1}}};
        end
        return r;
    endfunction

    // 41-bit difference saturated to signed 40
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] == v[POS_W-1]) begin
            r = v[POS_W-1:0];
        end else begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    // round scale 2^30 to Q1.15, saturating
    function automatic logic signed [ANG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        logic signed [ANG_W-1:0]  r;
        t = {v[CORDIC_W-1], v} + (CORDIC_W+1)'(16384);
        if (&t[CORDIC_W:30] || ~|t[CORDIC_W:30]) begin
            r = t[30:15];
        end else begin
            r = t[CORDIC_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [THR_W-1:0]            thr_reg;
    logic signed [POS_W-1:0]     off_x_reg, off_y_reg;
    logic signed [POS_W-1:0]     anchor_x_reg, anchor_y_reg;
    logic                        heading_ready_reg;
    logic signed [ANG_W-1:0]     held_heading_reg, held_quat_z_reg, held_quat_w_reg;

    logic signed [POS_W-1:0]     fix_x_reg, fix_y_reg;
    logic signed [POS_W-1:0]     map_x_reg, map_y_reg;
    logic signed [DIFF_W-1:0]    dx_reg, dy_reg;
    logic [2*THR_W-1:0]          t2_reg;
    logic [2*DIFF_W-1:0]         sqx_reg, sqy_reg;

    logic signed [CORDIC_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [Z_W-1:0]       cz_reg, cz_next;
    logic signed [ANG_W-1:0]     heading_next;

    logic signed [POS_W-1:0]     m_map_x_reg, m_map_y_reg;
    logic signed [ANG_W-1:0]     m_heading_reg, m_quat_z_reg, m_quat_w_reg;
    logic                        m_pose_valid_reg;

    // configuration and held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg           <= THRESHOLD_RST;
            off_x_reg         <= OFFSET_X_RST;
            off_y_reg         <= OFFSET_Y_RST;
            anchor_x_reg      <= '0;
            anchor_y_reg      <= '0;
            heading_ready_reg <= 1'b0;
            held_heading_reg  <= '0;
            held_quat_z_reg   <= '0;
            held_quat_w_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MOVE_THRESHOLD: thr_reg   <= cfg_wr_data[THR_W-1:0];
                    CFG_MAP_OFFSET_X:   off_x_reg <= cfg_wr_data;
                    CFG_MAP_OFFSET_Y:   off_y_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.h_round) begin
                held_heading_reg <= heading_next;
            end
            if (cmd.q_round) begin
                held_quat_z_reg   <= to_q15(cy_reg);
                held_quat_w_reg   <= to_q15(cx_reg);
                anchor_x_reg      <= fix_x_reg;
                anchor_y_reg      <= fix_y_reg;
                heading_ready_reg <= 1'b1;
            end
        end
    end

    // front end: capture, differences, squares
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            fix_x_reg <= s_fix_x;
            fix_y_reg <= s_fix_y;
        end
        if (cmd.diff) begin
            dx_reg    <= sat_diff({fix_x_reg[POS_W-1], fix_x_reg}
                                  - {anchor_x_reg[POS_W-1], anchor_x_reg});
            dy_reg    <= sat_diff({fix_y_reg[POS_W-1], fix_y_reg}
                                  - {anchor_y_reg[POS_W-1], anchor_y_reg});
            map_x_reg <= sat_pos({fix_x_reg[POS_W-1], fix_x_reg}
                                 - {off_x_reg[POS_W-1], off_x_reg});
            map_y_reg <= sat_pos({fix_y_reg[POS_W-1], fix_y_reg}
                                 - {off_y_reg[POS_W-1], off_y_reg});
            t2_reg    <= thr_reg * thr_reg;
        end
        if (cmd.sq_x) begin
            sqx_reg <= mag(dx_reg) * mag(dx_reg);
        end
        if (cmd.sq_y) begin
            sqy_reg <= mag(dy_reg) * mag(dy_reg);
        end
    end

    // each square is at most 2^62, so the sum cannot wrap
    assign status.moved = (sqx_reg + sqy_reg) > {{(2*DIFF_W-2*THR_W){1'b0}}, t2_reg};

    // shared CORDIC: vectoring for atan2, then rotation by heading/2
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [Z_W-1:0]      a_ext, zr;
    logic                       pos_dir;

    assign xs    = cx_reg >>> cmd.iter;
    assign ys    = cy_reg >>> cmd.iter;
    assign a_ext = $signed({{(Z_W-ATAN_W){1'b0}}, atan_lut(cmd.iter)});
    assign zr    = cz_reg + Z_W'(32768);
    assign heading_next = zr[31:16];

    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        // vectoring drives y to zero, rotation drives z to zero
        pos_dir = cmd.rot_mode ? cz_reg[Z_W-1]
                               : (!cy_reg[CORDIC_W-1] && (cy_reg != '0));
        priority if (cmd.vec_init) begin
            if (dx_reg[DIFF_W-1]) begin
                cx_next = -CORDIC_W'(dx_reg);
                cy_next = -CORDIC_W'(dy_reg);
                cz_next = dy_reg[DIFF_W-1] ? -(Z_W'(64'sd2147483648))
                                           : Z_W'(64'sd2147483648);
            end else begin
                cx_next = CORDIC_W'(dx_reg);
                cy_next = CORDIC_W'(dy_reg);
                cz_next = '0;
            end
        end else if (cmd.h_round) begin
            cx_next = GAIN_INV;
            cy_next = '0;
            cz_next = $signed({{(Z_W-ANG_W-15){heading_next[ANG_W-1]}}, heading_next, 15'b0});
        end else if (cmd.step) begin
            if (pos_dir) begin
                cx_next = cx_reg + ys;
                cy_next = cy_reg - xs;
                cz_next = cz_reg + a_ext;
            end else begin
                cx_next = cx_reg - ys;
                cy_next = cy_reg + xs;
                cz_next = cz_reg - a_ext;
            end
        end else begin
            cx_next = cx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
    end

    // result register; the held values it loads are zero until the heading is ready
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pose_valid_reg <= heading_ready_reg;
            m_heading_reg    <= held_heading_reg;
            m_quat_z_reg     <= held_quat_z_reg;
            m_quat_w_reg     <= held_quat_w_reg;
            m_map_x_reg      <= map_x_reg;
            m_map_y_reg      <= map_y_reg;
        end
    end

    assign m_pose_valid = m_pose_valid_reg;
    assign m_heading    = m_heading_reg;
    assign m_quat_z     = m_quat_z_reg;
    assign m_quat_w     = m_quat_w_reg;
    assign m_map_x      = m_map_x_reg;
    assign m_map_y      = m_map_y_reg;

    a_ready_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_ready_reg |=> heading_ready_reg)
        else $error("heading ready dropped without reset");

    a_zero_before_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !heading_ready_reg |-> (held_quat_z_reg == '0 && held_quat_w_reg == '0))
        else $error("orientation held before heading ready");

    a_update_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.q_round |=> (heading_ready_reg && anchor_x_reg == $past(fix_x_reg)))
        else $error("heading update did not move anchor");

endmodule

@@ rtl/core/gnss_heading_from_displacement_core.sv @@
// Top level: course-over-ground heading and map-frame pose from position fixes.
`timescale 1ns / 1ps

// Each position fix request yields one pose result. The map position is the
// fix minus the configured offset, saturated to 40 bits. When the fix lies
// more than move_threshold from the stored anchor, the heading is recomputed
// as atan2(dy, dx) by a vectoring CORDIC and the half-angle quaternion by a
// rotating CORDIC on the same shared iteration unit; the anchor then moves
// to the fix. Until the first update the orientation outputs read zero and
// pose_valid is low. One fix is processed at a time; when the heading updates,
// the vectoring and the rotating CORDIC pass each run N single-step
// iterations, N being min(CORDIC_ITERATIONS, 24). A new fix may
// be accepted while the previous result still waits in the output register.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wr_data
// and must only change while the core is idle.
module gnss_heading_from_displacement_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ghd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ghd_pkg::POS_W-1:0]            cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ghd_pkg::POS_W-1:0]     s_fix_x,
    input  logic signed [ghd_pkg::POS_W-1:0]     s_fix_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_pose_valid,
    output logic signed [ghd_pkg::ANG_W-1:0]     m_heading,
    output logic signed [ghd_pkg::ANG_W-1:0]     m_quat_z,
    output logic signed [ghd_pkg::ANG_W-1:0]     m_quat_w,
    output logic signed [ghd_pkg::POS_W-1:0]     m_map_x,
    output logic signed [ghd_pkg::POS_W-1:0]     m_map_y
);
    import ghd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ghd_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ghd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_fix_x      (s_fix_x),
        .s_fix_y      (s_fix_y),
        .cmd          (cmd),
        .status       (status),
        .m_pose_valid (m_pose_valid),
        .m_heading    (m_heading),
        .m_quat_z     (m_quat_z),
        .m_quat_w     (m_quat_w),
        .m_map_x      (m_map_x),
        .m_map_y      (m_map_y)
    );

endmodule
